FILE: rtl/core/graph_node_key_sorter_defines.svh
// Assertion macros for the graph node key sorter.
// No dependencies; included by the modules that carry assertions.
`ifndef GRAPH_NODE_KEY_SORTER_DEFINES_SVH
`define GRAPH_NODE_KEY_SORTER_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define GNKS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define GNKS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/gnks_pkg.sv
// Shared types, codes and helpers for the graph node key sorter.
// No dependencies.
package gnks_pkg;

	localparam int MAX_NODES_DEF = 64;
	localparam int VAL_W         = 64;
	localparam int POS_W         = 6;
	localparam int IDX_W         = 8;

	localparam logic KIND_LOAD    = 1'b0;
	localparam logic KIND_REMAP   = 1'b1;
	localparam logic RES_ORDER    = 1'b0;
	localparam logic RES_REMAP    = 1'b1;
	localparam logic MODE_NEWEST  = 1'b0;
	localparam logic MODE_OLDEST  = 1'b1;

	// Sort key, most significant part first.
	typedef struct packed {
		logic [VAL_W-1:0] tkey;
		logic [VAL_W-1:0] aid;
		logic [VAL_W-1:0] iid;
	} key_t;

	typedef struct packed {
		logic lt;
		logic gt;
	} cmp_res_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_REMAP,
		S_KEY_RD,
		S_KEY_CAP,
		S_CMP_RD,
		S_CMP,
		S_PLACE,
		S_EMIT_RD,
		S_EMIT
	} state_t;

	// Strictly positive as two's complement.
	function automatic logic is_positive(input logic [VAL_W-1:0] v);
		return !v[VAL_W-1] && (|v);
	endfunction

endpackage

FILE: rtl/core/gnks_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module gnks_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/core/gnks_cmp.sv
// Shared key comparator: signed lexicographic compare of two sort keys.
// Depends on gnks_pkg.
module gnks_cmp import gnks_pkg::*; (
	input  key_t     left,
	input  key_t     right,
	output cmp_res_t res
);

	logic t_lt, t_gt, a_lt, a_gt, i_lt, i_gt;

	always_comb begin
		t_lt = $signed(left.tkey) < $signed(right.tkey);
		t_gt = $signed(left.tkey) > $signed(right.tkey);
		a_lt = $signed(left.aid) < $signed(right.aid);
		a_gt = $signed(left.aid) > $signed(right.aid);
		i_lt = $signed(left.iid) < $signed(right.iid);
		i_gt = $signed(left.iid) > $signed(right.iid);
		res.lt = t_lt || (!t_gt && (a_lt || (!a_gt && i_lt)));
		res.gt = t_gt || (!t_lt && (a_gt || (!a_lt && i_gt)));
	end

endmodule

FILE: rtl/core/graph_node_key_sorter.sv
// Load: nodes are taken back to back while idle. Remap: the answer goes through S_REMAP
// into the output register once that is free; the next transfer waits for S_IDLE. Sort
// after the last node: each node is moved past its left neighbours, one key compare per
// order-memory read; the order is then emitted through S_EMIT as the output frees.
// Reset clears control, mode and counts; the memories are not cleared.
// Holds the top level: sequencer, key/order/map memories and output register.
// Depends on gnks_pkg, gnks_ram, gnks_cmp and the defines header.
`include "graph_node_key_sorter_defines.svh"
module graph_node_key_sorter import gnks_pkg::*; #(
	parameter int MAX_NODES = MAX_NODES_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic                    cfg_wdata,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    kind,
	input  logic signed [VAL_W-1:0] node_item_id,
	input  logic signed [VAL_W-1:0] node_created_time,
	input  logic signed [VAL_W-1:0] anchor_item_id,
	input  logic signed [VAL_W-1:0] anchor_created_time,
	input  logic                    last_node,
	input  logic signed [IDX_W-1:0] remap_index,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    result_kind,
	output logic [POS_W-1:0]        sorted_position,
	output logic [POS_W-1:0]        original_index,
	output logic                    order_changed,
	output logic signed [IDX_W-1:0] mapped_index,
	output logic                    last_result
);

	localparam int AW = $clog2(MAX_NODES);
	localparam int CW = $clog2(MAX_NODES + 1);

	state_t state_q, state_d;

	logic          sort_mode_q;
	logic [CW-1:0] count_q;
	logic          map_valid_q;
	logic [AW-1:0] i_q, j_q, p_q, prev_q;
	key_t          keyval_q;
	logic          changed_q;
	logic [IDX_W-1:0] raw_q;
	logic          hit_q;

	logic             out_valid_q;
	logic             out_kind_q;
	logic [POS_W-1:0] out_pos_q;
	logic [POS_W-1:0] out_orig_q;
	logic             out_changed_q;
	logic [IDX_W-1:0] out_mapped_q;
	logic             out_last_q;

	logic             in_fire, out_fire, out_free, out_load;
	logic [CW-1:0]    load_base;
	logic             load_store;
	logic [IDX_W-1:0] raw_in;
	logic             last_i, last_p, move, place;

	logic          key_we;
	key_t          key_wdata, key_rdata;
	logic [AW-1:0] key_raddr;
	logic          so_we;
	logic [AW-1:0] so_waddr, so_wdata, so_raddr, so_rdata;
	logic          map_we;
	logic [AW-1:0] map_raddr, map_rdata;
	cmp_res_t      cmp_res;

	assign in_ready   = (state_q == S_IDLE);
	assign in_fire    = in_valid && in_ready;
	assign out_fire   = out_valid_q && out_ready;
	assign out_free   = !out_valid_q || out_ready;
	assign raw_in     = remap_index;
	assign load_base  = map_valid_q ? '0 : count_q;
	assign load_store = load_base < CW'(MAX_NODES);
	assign key_we     = in_fire && (kind == KIND_LOAD) && load_store;
	assign last_i     = (CW'(i_q) + CW'(1)) == count_q;
	assign last_p     = (CW'(p_q) + CW'(1)) == count_q;
	assign move       = (sort_mode_q == MODE_OLDEST) ? cmp_res.gt : cmp_res.lt;
	assign map_raddr  = (state_q == S_IDLE) ? raw_in[AW-1:0] : raw_q[AW-1:0];

	always_comb begin
		key_wdata.iid  = node_item_id;
		key_wdata.tkey = is_positive(anchor_created_time) ? anchor_created_time
		                                                   : node_created_time;
		key_wdata.aid  = is_positive(anchor_item_id) ? anchor_item_id : node_item_id;
	end

	gnks_ram #(.WIDTH($bits(key_t)), .DEPTH(MAX_NODES)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (load_base[AW-1:0]),
		.wdata (key_wdata),
		.raddr (key_raddr),
		.rdata (key_rdata)
	);

	gnks_ram #(.WIDTH(AW), .DEPTH(MAX_NODES)) u_order_ram (
		.clk   (clk),
		.we    (so_we),
		.waddr (so_waddr),
		.wdata (so_wdata),
		.raddr (so_raddr),
		.rdata (so_rdata)
	);

	// old index -> new position, written as the order is emitted
	gnks_ram #(.WIDTH(AW), .DEPTH(MAX_NODES)) u_map_ram (
		.clk   (clk),
		.we    (map_we),
		.waddr (so_rdata),
		.wdata (p_q),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	// left: node just before the insertion gap, right: node being inserted
	gnks_cmp u_cmp (
		.left  (key_rdata),
		.right (keyval_q),
		.res   (cmp_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		key_raddr = i_q;
		so_we     = 1'b0;
		so_waddr  = j_q;
		so_wdata  = i_q;
		so_raddr  = p_q;
		map_we    = 1'b0;
		out_load  = 1'b0;
		place     = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					if (kind == KIND_REMAP) begin
						state_d = S_REMAP;
					end else if (last_node) begin
						state_d = S_KEY_RD;
					end
				end
			end
			S_REMAP: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_KEY_RD: begin
				state_d = S_KEY_CAP;
			end
			S_KEY_CAP: begin
				if (i_q == '0) begin
					so_we   = 1'b1;
					place   = 1'b1;
					state_d = last_i ? S_EMIT_RD : S_KEY_RD;
				end else begin
					so_raddr = i_q - AW'(1);
					state_d  = S_CMP_RD;
				end
			end
			S_CMP_RD: begin
				key_raddr = so_rdata;
				state_d   = S_CMP;
			end
			S_CMP: begin
				so_we = 1'b1;
				if (move) begin
					// shift the left neighbour one place right
					so_wdata = prev_q;
					if (j_q == AW'(1)) begin
						state_d = S_PLACE;
					end else begin
						so_raddr = j_q - AW'(2);
						state_d  = S_CMP_RD;
					end
				end else begin
					place   = 1'b1;
					state_d = last_i ? S_EMIT_RD : S_KEY_RD;
				end
			end
			S_PLACE: begin
				so_we   = 1'b1;
				place   = 1'b1;
				state_d = last_i ? S_EMIT_RD : S_KEY_RD;
			end
			S_EMIT_RD: begin
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					map_we   = 1'b1;
					if (last_p) begin
						state_d = S_IDLE;
					end else begin
						so_raddr = p_q + AW'(1);
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sort_mode_q <= MODE_NEWEST;
			count_q     <= '0;
			map_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				sort_mode_q <= cfg_wdata;
			end
			if (in_fire && (kind == KIND_LOAD)) begin
				map_valid_q <= 1'b0;
				count_q     <= load_store ? load_base + CW'(1) : load_base;
			end
			if ((state_q == S_EMIT) && out_load && last_p) begin
				map_valid_q <= 1'b1;
			end
			if (out_fire) begin
				out_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			raw_q <= raw_in;
			hit_q <= map_valid_q && !raw_in[IDX_W-1] && (raw_in < IDX_W'(count_q));
			if ((kind == KIND_LOAD) && last_node) begin
				i_q       <= '0;
				p_q       <= '0;
				changed_q <= 1'b0;
			end
		end
		if (state_q == S_KEY_RD) begin
			j_q <= i_q;
		end
		if (state_q == S_KEY_CAP) begin
			keyval_q <= key_rdata;
		end
		if (state_q == S_CMP_RD) begin
			prev_q <= so_rdata;
		end
		if ((state_q == S_CMP) && move) begin
			j_q       <= j_q - AW'(1);
			changed_q <= 1'b1;
		end
		if (place) begin
			i_q <= i_q + AW'(1);
		end
		if ((state_q == S_EMIT) && out_load) begin
			p_q <= p_q + AW'(1);
		end
		if (out_load) begin
			if (state_q == S_REMAP) begin
				out_kind_q    <= RES_REMAP;
				out_pos_q     <= '0;
				out_orig_q    <= '0;
				out_changed_q <= 1'b0;
				out_mapped_q  <= hit_q ? IDX_W'(map_rdata) : raw_q;
				out_last_q    <= 1'b1;
			end else begin
				out_kind_q    <= RES_ORDER;
				out_pos_q     <= POS_W'(p_q);
				out_orig_q    <= POS_W'(so_rdata);
				out_changed_q <= changed_q;
				out_mapped_q  <= '0;
				out_last_q    <= last_p;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign result_kind     = out_kind_q;
	assign sorted_position = out_pos_q;
	assign original_index  = out_orig_q;
	assign order_changed   = out_changed_q;
	assign mapped_index    = out_mapped_q;
	assign last_result     = out_last_q;

	`GNKS_ASSERT_NOW(a_cmp_has_left, state_q == S_CMP_RD, j_q != '0, "compare with no left neighbour")
	`GNKS_ASSERT_NOW(a_gap_le_i, state_q == S_CMP_RD || state_q == S_CMP || state_q == S_PLACE, j_q <= i_q, "insertion gap beyond node")
	`GNKS_ASSERT_NOW(a_i_in_range, state_q == S_KEY_RD || state_q == S_KEY_CAP, CW'(i_q) < count_q, "insert index past loaded count")
	`GNKS_ASSERT_NOW(a_changed_seen, state_q == S_EMIT && out_free && so_rdata != p_q, changed_q, "reordered entry without changed flag")
	`GNKS_ASSERT_NEXT(a_map_ready, state_q == S_EMIT && out_free && last_p, map_valid_q && state_q == S_IDLE, "map not valid after last entry")

endmodule

FILE: sim/graph_node_key_sorter_tb.sv
// Testbench for graph_node_key_sorter: node loads, stable key sort in both orders, index remap.
// Scoreboard against an in-bench sort model, with random handshake gaps and an output hold-off.
// Depends on gnks_pkg and the graph_node_key_sorter RTL.
module graph_node_key_sorter_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import gnks_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 40;

	typedef struct {
		logic                    kind;
		logic signed [VAL_W-1:0] node_item_id;
		logic signed [VAL_W-1:0] node_created_time;
		logic signed [VAL_W-1:0] anchor_item_id;
		logic signed [VAL_W-1:0] anchor_created_time;
		logic                    last_node;
		logic signed [IDX_W-1:0] remap_index;
	} node_item_t;

	typedef struct {
		logic                    rkind;
		logic [POS_W-1:0]        pos;
		logic [POS_W-1:0]        orig;
		logic                    changed;
		logic signed [IDX_W-1:0] mapped;
		logic                    is_last;
	} sorter_result_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_we = 1'b0;
	logic                    cfg_wdata = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic                    kind = KIND_LOAD;
	logic signed [VAL_W-1:0] node_item_id = '0;
	logic signed [VAL_W-1:0] node_created_time = '0;
	logic signed [VAL_W-1:0] anchor_item_id = '0;
	logic signed [VAL_W-1:0] anchor_created_time = '0;
	logic                    last_node = 1'b0;
	logic signed [IDX_W-1:0] remap_index = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic                    result_kind;
	logic [POS_W-1:0]        sorted_position;
	logic [POS_W-1:0]        original_index;
	logic                    order_changed;
	logic signed [IDX_W-1:0] mapped_index;
	logic                    last_result;

	// model state
	logic signed [VAL_W-1:0] time_key [MAX_NODES_DEF];
	logic signed [VAL_W-1:0] anchor_key [MAX_NODES_DEF];
	logic signed [VAL_W-1:0] item_key [MAX_NODES_DEF];
	logic [POS_W-1:0]        new_pos_of [MAX_NODES_DEF];
	int                      nodes_held = 0;
	bit                      map_ready = 1'b0;
	logic                    oldest_first = MODE_NEWEST;

	sorter_result_t answers_due [$];

	int  errors = 0;
	int  cycle_count = 0;
	int  send_idle_pct = 0;
	int  recv_idle_pct = 0;
	int  hold_request = 0;
	int  hold_left = 0;
	int  loads_sent = 0;
	int  remaps_sent = 0;
	int  sorts_done = 0;
	int  results_checked = 0;

	graph_node_key_sorter dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg_we),
		.cfg_wdata           (cfg_wdata),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.kind                (kind),
		.node_item_id        (node_item_id),
		.node_created_time   (node_created_time),
		.anchor_item_id      (anchor_item_id),
		.anchor_created_time (anchor_created_time),
		.last_node           (last_node),
		.remap_index         (remap_index),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.result_kind         (result_kind),
		.sorted_position     (sorted_position),
		.original_index      (original_index),
		.order_changed       (order_changed),
		.mapped_index        (mapped_index),
		.last_result         (last_result)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				answers_due.size());
			$display("graph_node_key_sorter_tb failed");
			$finish;
		end
	end

	// receiver: long hold-off when requested, otherwise random back-pressure
	always @(negedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		if (errors < 40)
			$display("MISMATCH cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin : check_results
		sorter_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (answers_due.size() == 0) begin
				report_mismatch("unexpected result, kind", result_kind, 0);
			end else begin
				want = answers_due.pop_front();
				results_checked++;
				if (result_kind !== want.rkind)
					report_mismatch("result_kind", result_kind, want.rkind);
				if (sorted_position !== want.pos)
					report_mismatch("sorted_position", sorted_position, want.pos);
				if (original_index !== want.orig)
					report_mismatch("original_index", original_index, want.orig);
				if (order_changed !== want.changed)
					report_mismatch("order_changed", order_changed, want.changed);
				if (mapped_index !== want.mapped)
					report_mismatch("mapped_index", mapped_index, want.mapped);
				if (last_result !== want.is_last)
					report_mismatch("last_result", last_result, want.is_last);
			end
		end
	end

	// three-way compare on (time, anchor id, item id), signed
	function automatic int key_order(input int a, input int b);
		if (time_key[a] != time_key[b])
			return (time_key[a] < time_key[b]) ? -1 : 1;
		if (anchor_key[a] != anchor_key[b])
			return (anchor_key[a] < anchor_key[b]) ? -1 : 1;
		if (item_key[a] != item_key[b])
			return (item_key[a] < item_key[b]) ? -1 : 1;
		return 0;
	endfunction

	task automatic sort_and_map(input node_item_t it);
		int             order [MAX_NODES_DEF];
		int             i;
		int             j;
		int             moving;
		int             c;
		bit             changed;
		sorter_result_t r;
		r.rkind = RES_ORDER;
		r.pos = '0;
		r.orig = '0;
		r.changed = 1'b0;
		r.mapped = '0;
		r.is_last = 1'b1;
		if (it.kind == KIND_REMAP) begin
			r.rkind = RES_REMAP;
			r.mapped = it.remap_index;
			if (map_ready && it.remap_index >= 0 && int'(it.remap_index) < nodes_held)
				r.mapped = {2'b00, new_pos_of[it.remap_index[POS_W-1:0]]};
			answers_due.push_back(r);
			return;
		end
		if (map_ready) begin
			map_ready = 1'b0;
			nodes_held = 0;
		end
		// a full store drops the node but still honours last_node
		if (nodes_held < MAX_NODES_DEF) begin
			item_key[nodes_held] = it.node_item_id;
			time_key[nodes_held] = (it.anchor_created_time > 0) ? it.anchor_created_time
				: it.node_created_time;
			anchor_key[nodes_held] = (it.anchor_item_id > 0) ? it.anchor_item_id
				: it.node_item_id;
			nodes_held++;
		end
		if (!it.last_node)
			return;
		for (i = 0; i < nodes_held; i++)
			order[i] = i;
		for (i = 1; i < nodes_held; i++) begin
			moving = order[i];
			j = i;
			while (j > 0) begin
				c = key_order(order[j-1], moving);
				if (oldest_first ? (c <= 0) : (c >= 0))
					break;
				order[j] = order[j-1];
				j--;
			end
			order[j] = moving;
		end
		changed = 1'b0;
		for (i = 0; i < nodes_held; i++) begin
			if (order[i] != i)
				changed = 1'b1;
			new_pos_of[order[i]] = POS_W'(i);
		end
		map_ready = 1'b1;
		sorts_done++;
		for (i = 0; i < nodes_held; i++) begin
			r.pos = POS_W'(i);
			r.orig = POS_W'(order[i]);
			r.changed = changed;
			r.is_last = (i == nodes_held - 1);
			answers_due.push_back(r);
		end
	endtask

	// mix of small values (ties), extremes and full-width patterns
	function automatic logic signed [VAL_W-1:0] rand_key();
		logic signed [VAL_W-1:0] v;
		case ($urandom_range(5))
			0, 1: begin
				v = VAL_W'($urandom_range(4));
				v = v - 64'sd2;
			end
			2: begin
				case ($urandom_range(3))
					0: v = 64'h7fff_ffff_ffff_ffff;
					1: v = 64'h8000_0000_0000_0000;
					2: v = -64'sd1;
					default: v = 64'sd1;
				endcase
			end
			default: v = {$urandom, $urandom};
		endcase
		return v;
	endfunction

	function automatic logic signed [IDX_W-1:0] rand_index(input int n);
		case ($urandom_range(19))
			0, 1, 2: return IDX_W'($urandom_range(128, 255));
			3, 4, 5: return IDX_W'($urandom_range(n, 127));
			default: return IDX_W'($urandom_range(0, n - 1));
		endcase
	endfunction

	function automatic node_item_t make_load(input logic signed [VAL_W-1:0] iid, ctime, aid,
			atime, input logic is_last);
		node_item_t it;
		it.kind = KIND_LOAD;
		it.node_item_id = iid;
		it.node_created_time = ctime;
		it.anchor_item_id = aid;
		it.anchor_created_time = atime;
		it.last_node = is_last;
		it.remap_index = IDX_W'($urandom);
		return it;
	endfunction

	function automatic node_item_t make_remap(input logic signed [IDX_W-1:0] idx);
		node_item_t it;
		it.kind = KIND_REMAP;
		it.node_item_id = {$urandom, $urandom};
		it.node_created_time = {$urandom, $urandom};
		it.anchor_item_id = {$urandom, $urandom};
		it.anchor_created_time = {$urandom, $urandom};
		it.last_node = 1'($urandom_range(1));
		it.remap_index = idx;
		return it;
	endfunction

	function automatic node_item_t rand_load(input logic is_last);
		return make_load(rand_key(), rand_key(), rand_key(), rand_key(), is_last);
	endfunction

	// one transfer on the input channel, with optional idle cycles ahead of it
	task automatic send_item(input node_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		kind <= it.kind;
		node_item_id <= it.node_item_id;
		node_created_time <= it.node_created_time;
		anchor_item_id <= it.anchor_item_id;
		anchor_created_time <= it.anchor_created_time;
		last_node <= it.last_node;
		remap_index <= it.remap_index;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		if (it.kind == KIND_REMAP)
			remaps_sent++;
		else
			loads_sent++;
		sort_and_map(it);
	endtask

	// stop offering, wait for every result, then let any trailing work finish
	task automatic drain_block();
		@(negedge clk);
		in_valid <= 1'b0;
		while (answers_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input logic m);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(negedge clk);
		cfg_we <= 1'b0;
		oldest_first = m;
	endtask

	task automatic send_batch(input int n, input int queries, input bit noisy);
		int i;
		for (i = 0; i < n; i++) begin
			// a stray query before the first load sees the last map; later ones see no valid map
			if (noisy && $urandom_range(9) == 0)
				send_item(make_remap(rand_index(n)));
			send_item(rand_load(i == n - 1));
		end
		for (i = 0; i < queries; i++)
			send_item(make_remap(rand_index(n)));
	endtask

	task automatic test_remap_before_sort();
		send_item(make_remap(8'sd0));
		send_item(make_remap(8'sd127));
		send_item(make_remap(-8'sd128));
	endtask

	task automatic test_single_node();
		drain_block();
		write_mode(MODE_OLDEST);
		send_item(rand_load(1'b1));
		send_item(make_remap(8'sd0));
		send_item(make_remap(8'sd1));
	endtask

	// fallback of non-positive anchors, extremes, full ties for stability
	task automatic test_key_extremes(input logic m);
		logic signed [VAL_W-1:0] smax;
		logic signed [VAL_W-1:0] smin;
		smax = 64'h7fff_ffff_ffff_ffff;
		smin = 64'h8000_0000_0000_0000;
		drain_block();
		write_mode(m);
		send_item(make_load(64'sd5, 64'sd100, 64'sd0, 64'sd0, 1'b0));
		send_item(make_load(64'sd7, 64'sd100, -64'sd1, 64'sd100, 1'b0));
		send_item(make_load(smin, smax, smax, smin, 1'b0));
		send_item(make_load(smax, smin, 64'sd3, 64'sd1, 1'b0));
		send_item(make_load(64'sd5, 64'sd100, 64'sd0, 64'sd0, 1'b0));
		send_item(make_load(64'sd5, -64'sd50, smin, 64'sd100, 1'b1));
		send_item(make_remap(8'sd0));
		send_item(make_remap(8'sd5));
		send_item(make_remap(8'sd6));
	endtask

	// mode is taken when the sort runs, not when the batch starts
	task automatic test_mode_mid_batch();
		drain_block();
		write_mode(MODE_NEWEST);
		send_item(rand_load(1'b0));
		send_item(rand_load(1'b0));
		drain_block();
		write_mode(MODE_OLDEST);
		send_item(rand_load(1'b1));
		send_item(make_remap(-8'sd1));
	endtask

	task automatic test_full_store(input logic m);
		int i;
		int n;
		drain_block();
		write_mode(m);
		n = MAX_NODES_DEF + $urandom_range(1, 6);
		for (i = 0; i < n; i++)
			send_item(rand_load(i == n - 1));
		send_item(make_remap(8'sd63));
		send_item(make_remap(8'sd64));
		send_item(make_remap(8'sd0));
	endtask

	// receiver blocked long enough that the block fills and stalls its input
	task automatic test_output_stall();
		drain_block();
		@(posedge clk);
		hold_request = 1500;
		send_batch(12, 12, 1'b0);
		drain_block();
	endtask

	task automatic test_random_traffic(input int quota, input bit flip_mode);
		int start;
		int sel;
		int n;
		start = loads_sent + remaps_sent;
		while (loads_sent + remaps_sent - start < quota) begin
			if (flip_mode && $urandom_range(2) == 0) begin
				drain_block();
				write_mode(1'($urandom_range(1)));
			end
			sel = $urandom_range(19);
			n = (sel < 16) ? $urandom_range(1, 8) : $urandom_range(9, 20);
			send_batch(n, $urandom_range(0, 6), 1'b1);
			if ($urandom_range(5) == 0)
				drain_block();
		end
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct = 37;
		recv_idle_pct = 51;
		test_remap_before_sort();
		test_single_node();
		test_key_extremes(MODE_NEWEST);
		test_key_extremes(MODE_OLDEST);
		test_mode_mid_batch();
		test_full_store(MODE_NEWEST);
		drain_block();
		write_mode(MODE_NEWEST);
		test_random_traffic(50, 1'b0);

		drain_block();
		send_idle_pct = 51;
		recv_idle_pct = 37;
		test_full_store(MODE_OLDEST);
		test_random_traffic(50, 1'b0);

		drain_block();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_output_stall();
		test_random_traffic(60, 1'b1);

		drain_block();
		if (answers_due.size() != 0)
			report_mismatch("results never delivered", answers_due.size(), 0);
		$display("run covered %0d node loads and %0d remap queries, %0d sorts in both orders",
			loads_sent, remaps_sent, sorts_done);
		$display("%0d results checked, %0d mismatches, %0d cycles", results_checked, errors,
			cycle_count);
		if (errors == 0) begin
			$display("graph_node_key_sorter_tb passed");
		end else begin
			$display("graph_node_key_sorter_tb failed");
		end
		$finish;
	end

endmodule
